@@ hw/rtl/wsd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsd_pkg
// Shared types and constants of the WebSocket frame deframer.
// ----------------------------------------------------------------------------
package wsd_pkg;

  localparam int unsigned MAX_LEN_W = 32;
  localparam int unsigned LEN_W     = 64;

  localparam logic [MAX_LEN_W-1:0] MAX_LEN_RESET = 32'd1024;

  // result kinds
  localparam logic [1:0] KIND_BYTE    = 2'd0;
  localparam logic [1:0] KIND_EMPTY   = 2'd1;
  localparam logic [1:0] KIND_TOOLONG = 2'd2;

  // header decode constants
  localparam logic [6:0] LEN_CODE_16 = 7'd126;
  localparam logic [6:0] LEN_CODE_64 = 7'd127;

  // result queue between parser and output stage
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = $clog2(QDEPTH);

  // one queued result: raw byte and key byte, unmasked in the back end
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic [7:0] key;
    logic       last;
    logic       fin;
    logic [3:0] opcode;
  } wsd_rec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } wsd_qstat_t;

endpackage

@@ hw/rtl/wsd_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsd_front
// Header parser: takes one stream byte per cycle unless the queue is full,
// tracks the frame phase and queues one result record per byte with a result.
// ----------------------------------------------------------------------------
module wsd_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [31:0]               cfg_data,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [7:0]                in_tdata,
  input  wsd_pkg::wsd_qstat_t       q_stat,
  output logic                      q_push,
  output wsd_pkg::wsd_rec_t         q_rec
);
  import wsd_pkg::*;

  localparam logic [2:0] PH_HDR0 = 3'd0;
  localparam logic [2:0] PH_HDR1 = 3'd1;
  localparam logic [2:0] PH_EXT  = 3'd2;
  localparam logic [2:0] PH_MASK = 3'd3;
  localparam logic [2:0] PH_DATA = 3'd4;

  logic [MAX_LEN_W-1:0] max_len_r;
  logic [2:0]           phase_r, phase_nxt;
  logic                 fin_r, fin_nxt;
  logic [3:0]           opcode_r, opcode_nxt;
  logic                 mask_r, mask_nxt;
  logic [LEN_W-1:0]     len_r, len_nxt;
  logic [2:0]           cnt_r, cnt_nxt;
  logic [31:0]          key_r, key_nxt;
  logic [1:0]           idx_r, idx_nxt;
  logic                 drop_r, drop_nxt;

  logic                 accept;
  logic [LEN_W-1:0]     len_shift;
  logic [LEN_W-1:0]     len_chk;
  logic [LEN_W-1:0]     len_dec;
  logic                 too_long;
  logic [2:0]           cnt_dec;
  logic [7:0]           key_byte;

  assign cfg_ready = 1'b1;
  assign in_tready = ~q_stat.full;
  assign accept    = in_tvalid & in_tready;

  assign len_shift = {len_r[LEN_W-9:0], in_tdata};
  assign len_chk   = (phase_r == PH_HDR1) ? {{(LEN_W-7){1'b0}}, in_tdata[6:0]} : len_shift;
  assign too_long  = (len_chk[LEN_W-1:MAX_LEN_W] != '0) ||
                     (len_chk[MAX_LEN_W-1:0] > max_len_r);
  assign len_dec   = len_r - {{(LEN_W-1){1'b0}}, 1'b1};
  assign cnt_dec   = cnt_r - 3'd1;

  always_comb begin
    case (idx_r)
      2'd0:    key_byte = key_r[31:24];
      2'd1:    key_byte = key_r[23:16];
      2'd2:    key_byte = key_r[15:8];
      default: key_byte = key_r[7:0];
    endcase
  end

  always_comb begin
    phase_nxt  = phase_r;
    fin_nxt    = fin_r;
    opcode_nxt = opcode_r;
    mask_nxt   = mask_r;
    len_nxt    = len_r;
    cnt_nxt    = cnt_r;
    key_nxt    = key_r;
    idx_nxt    = idx_r;
    drop_nxt   = drop_r;
    q_push     = 1'b0;
    q_rec      = '{kind: KIND_EMPTY, data: 8'd0, key: 8'd0, last: 1'b1,
                   fin: fin_r, opcode: opcode_r};
    if (accept) begin
      case (phase_r)
        PH_HDR0: begin
          fin_nxt    = in_tdata[7];
          opcode_nxt = in_tdata[3:0];
          key_nxt    = '0;
          idx_nxt    = '0;
          drop_nxt   = 1'b0;
          len_nxt    = '0;
          phase_nxt  = PH_HDR1;
        end
        PH_HDR1, PH_EXT: begin
          if (phase_r == PH_HDR1) begin
            mask_nxt = in_tdata[7];
          end
          cnt_nxt = (phase_r == PH_EXT) ? cnt_dec : cnt_r;
          len_nxt = len_chk;
          if (phase_r == PH_HDR1 && in_tdata[6:0] == LEN_CODE_16) begin
            len_nxt   = '0;
            cnt_nxt   = 3'd2;
            phase_nxt = PH_EXT;
          end else if (phase_r == PH_HDR1 && in_tdata[6:0] == LEN_CODE_64) begin
            // eight bytes: the counter wraps through 7 down to 0
            len_nxt   = '0;
            cnt_nxt   = 3'd0;
            phase_nxt = PH_EXT;
          end else if (phase_r == PH_HDR1 || cnt_dec == 3'd0) begin
            // length complete
            drop_nxt = too_long;
            if (too_long) begin
              q_push      = 1'b1;
              q_rec.kind  = KIND_TOOLONG;
            end
            if (mask_nxt) begin
              cnt_nxt   = 3'd4;
              phase_nxt = PH_MASK;
            end else if (len_chk == '0) begin
              q_push    = 1'b1;
              q_rec.kind = KIND_EMPTY;
              phase_nxt = PH_HDR0;
            end else begin
              phase_nxt = PH_DATA;
            end
          end
        end
        PH_MASK: begin
          key_nxt = {key_r[23:0], in_tdata};
          cnt_nxt = cnt_dec;
          if (cnt_dec == 3'd0) begin
            if (len_r == '0) begin
              phase_nxt  = PH_HDR0;
              q_push     = ~drop_r;
              q_rec.kind = KIND_EMPTY;
            end else begin
              phase_nxt = PH_DATA;
            end
          end
        end
        PH_DATA: begin
          len_nxt = len_dec;
          if (len_dec == '0) begin
            phase_nxt = PH_HDR0;
          end
          if (!drop_r) begin
            q_push     = 1'b1;
            q_rec.kind = KIND_BYTE;
            q_rec.data = in_tdata;
            q_rec.key  = key_byte;
            q_rec.last = (len_dec == '0);
            idx_nxt    = idx_r + 2'd1;
          end
        end
        default: begin
          phase_nxt = PH_HDR0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= MAX_LEN_RESET;
      phase_r   <= PH_HDR0;
      fin_r     <= 1'b0;
      opcode_r  <= '0;
      mask_r    <= 1'b0;
      len_r     <= '0;
      cnt_r     <= '0;
      key_r     <= '0;
      idx_r     <= '0;
      drop_r    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        max_len_r <= cfg_data;
      end
      phase_r  <= phase_nxt;
      fin_r    <= fin_nxt;
      opcode_r <= opcode_nxt;
      mask_r   <= mask_nxt;
      len_r    <= len_nxt;
      cnt_r    <= cnt_nxt;
      key_r    <= key_nxt;
      idx_r    <= idx_nxt;
      drop_r   <= drop_nxt;
    end
  end

`ifndef SYNTHESIS
  a_no_byte_when_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (q_push && q_rec.kind == KIND_BYTE) |-> !drop_r)
    else $error("payload byte queued for a dropped frame");

  a_nonbyte_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (q_push && q_rec.kind != KIND_BYTE) |-> (q_rec.last && q_rec.data == 8'd0))
    else $error("empty or error result not marked last");

  a_phase_legal: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r <= PH_DATA)
    else $error("parser phase out of range");

  a_data_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DATA) |-> (len_r != '0))
    else $error("payload phase with no bytes left");
`endif

endmodule

@@ hw/rtl/wsd_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsd_fifo
// Short result queue that decouples the parser from the output stage.
// ----------------------------------------------------------------------------
module wsd_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  wsd_pkg::wsd_rec_t   push_rec,
  input  logic                pop,
  output wsd_pkg::wsd_rec_t   pop_rec,
  output wsd_pkg::wsd_qstat_t stat
);
  import wsd_pkg::*;

  wsd_rec_t       mem_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QAW:0]   count_r, count_nxt;

  assign stat.full  = (count_r == QDEPTH[QAW:0]);
  assign stat.empty = (count_r == '0);
  assign pop_rec    = mem_r[rd_ptr_r];

  assign wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
  assign rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !stat.full)
    else $error("result queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !stat.empty)
    else $error("result queue underflow");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QDEPTH[QAW:0])
    else $error("result queue count out of range");
`endif

endmodule

@@ hw/rtl/wsd_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsd_back
// Output stage: pops queued results, unmasks payload bytes and holds the
// outgoing word in a register until it is taken.
// ----------------------------------------------------------------------------
module wsd_back (
  input  logic                clk,
  input  logic                rst_n,
  input  wsd_pkg::wsd_qstat_t q_stat,
  input  wsd_pkg::wsd_rec_t   q_rec,
  output logic                q_pop,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [15:0]         out_tdata,
  output logic [1:0]          out_tuser,
  output logic                out_tlast
);
  import wsd_pkg::*;

  logic        valid_r;
  logic [15:0] data_r;
  logic [1:0]  user_r;
  logic        last_r;

  // refill the output register when it is empty or being taken
  assign q_pop = ~q_stat.empty & (~valid_r | out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (q_pop) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      data_r <= {3'b000, q_rec.opcode, q_rec.fin, q_rec.data ^ q_rec.key};
      user_r <= q_rec.kind;
      last_r <= q_rec.last;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;
  assign out_tuser  = user_r;
  assign out_tlast  = last_r;

endmodule

@@ hw/rtl/websocket_frame_deframer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// websocket_frame_deframer
// Receive-side WebSocket frame parser: header decode, length check against
// a programmable limit, payload unmasking, one byte per cycle unless stalled.
// ----------------------------------------------------------------------------
// channel  dir  handshake               payload
// cfg      in   cfg_valid/cfg_ready     cfg_data: max payload length (32b)
// in       in   in_tvalid/in_tready     in_tdata: received stream byte
// out      out  out_tvalid/out_tready   out_tdata/out_tuser/out_tlast
//
// One byte is taken per cycle while in_tready is high; the parser updates its
// frame state in that cycle and queues at most one result. Each result goes
// through the queue, then the output register. The 4-entry result queue lets
// the input run on while the output stalls; in_tready drops only when it is
// full. Synchronous active-low reset returns to the first header byte and
// restores the length limit to 1024; no clearing pass is needed.
// ----------------------------------------------------------------------------
module websocket_frame_deframer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data,    // [31:0] max_payload_length
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] in_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,   // [7:0] data_byte, [8] fin_bit,
                                   // [12:9] frame_opcode, [15:13] zero
  output logic [1:0]  out_tuser,   // [1:0] result_kind
  output logic        out_tlast    // last_of_frame
);
  import wsd_pkg::*;

  wsd_qstat_t q_stat;
  wsd_rec_t   push_rec;
  wsd_rec_t   pop_rec;
  logic       q_push;
  logic       q_pop;

  wsd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_stat    (q_stat),
    .q_push    (q_push),
    .q_rec     (push_rec)
  );

  wsd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_rec (push_rec),
    .pop      (q_pop),
    .pop_rec  (pop_rec),
    .stat     (q_stat)
  );

  wsd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_stat     (q_stat),
    .q_rec      (pop_rec),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

@@ dv/tb_websocket_frame_deframer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_websocket_frame_deframer
// Self-checking bench for the WebSocket frame deframer. Frames are built byte
// by byte (short, 16-bit and 64-bit length codes, masked and unmasked, over
// and under the length limit) and fed through the input stream with random
// gaps. A local parser follows every accepted word and queues the results it
// predicts; a checker compares each output word against the oldest one.
// ----------------------------------------------------------------------------
module tb_websocket_frame_deframer;
  import wsd_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned RANDOM_BYTES = 45;

  typedef enum logic [2:0] {
    ST_HDR0, ST_HDR1, ST_EXT, ST_MASK, ST_DATA
  } parse_st_t;

  typedef enum logic [1:0] {ENC_SHORT, ENC_16, ENC_64} len_enc_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic       last;
    logic       fin;
    logic [3:0] opcode;
  } frame_result_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [31:0] cfg_data;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;

  websocket_frame_deframer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  // parser state mirrored by the bench
  parse_st_t   hdr_state;
  logic        cur_fin;
  logic [3:0]  cur_opcode;
  logic        cur_masked;
  logic [63:0] bytes_left;
  logic [3:0]  field_count;
  logic [31:0] cur_key;
  logic [1:0]  key_pos;
  logic        cur_dropped;
  logic [31:0] length_limit;

  frame_result_t expected_results[$];
  int unsigned   mismatch_count;
  int unsigned   bytes_sent;
  int unsigned   cycle_count;

  // pacing controls
  bit          tx_idle_on;
  bit          rx_idle_on;
  int unsigned rx_hold;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void queue_result(input logic [1:0] kind, input logic [7:0] data,
                                       input logic last);
    frame_result_t r;
    r.kind   = kind;
    r.data   = data;
    r.last   = last;
    r.fin    = cur_fin;
    r.opcode = cur_opcode;
    expected_results.push_back(r);
  endfunction

  function automatic void parser_reset();
    hdr_state    = ST_HDR0;
    cur_fin      = 1'b0;
    cur_opcode   = 4'd0;
    cur_masked   = 1'b0;
    bytes_left   = '0;
    field_count  = '0;
    cur_key      = '0;
    key_pos      = '0;
    cur_dropped  = 1'b0;
    length_limit = MAX_LEN_RESET;
  endfunction

  // length is complete: check the limit, then go to key, payload or next header
  function automatic void finish_length();
    cur_dropped = (bytes_left > {32'd0, length_limit});
    if (cur_dropped) queue_result(KIND_TOOLONG, 8'h00, 1'b1);
    if (cur_masked) begin
      field_count = 4'd4;
      hdr_state   = ST_MASK;
    end else if (bytes_left == 0) begin
      queue_result(KIND_EMPTY, 8'h00, 1'b1);
      hdr_state = ST_HDR0;
    end else begin
      hdr_state = ST_DATA;
    end
  endfunction

  function automatic void deframe_byte(input logic [7:0] b);
    logic [7:0] kb;
    logic       last;
    case (hdr_state)
      ST_HDR0: begin
        cur_fin     = b[7];
        cur_opcode  = b[3:0];
        cur_key     = '0;
        key_pos     = '0;
        cur_dropped = 1'b0;
        bytes_left  = '0;
        hdr_state   = ST_HDR1;
      end
      ST_HDR1: begin
        cur_masked = b[7];
        bytes_left = '0;
        if (b[6:0] == LEN_CODE_16) begin
          field_count = 4'd2;
          hdr_state   = ST_EXT;
        end else if (b[6:0] == LEN_CODE_64) begin
          field_count = 4'd8;
          hdr_state   = ST_EXT;
        end else begin
          bytes_left = {57'd0, b[6:0]};
          finish_length();
        end
      end
      ST_EXT: begin
        bytes_left  = {bytes_left[55:0], b};
        field_count = field_count - 1'b1;
        if (field_count == 0) finish_length();
      end
      ST_MASK: begin
        cur_key     = {cur_key[23:0], b};
        field_count = field_count - 1'b1;
        if (field_count == 0) begin
          if (bytes_left == 0) begin
            hdr_state = ST_HDR0;
            if (!cur_dropped) queue_result(KIND_EMPTY, 8'h00, 1'b1);
          end else begin
            hdr_state = ST_DATA;
          end
        end
      end
      ST_DATA: begin
        bytes_left = bytes_left - 1'b1;
        last       = (bytes_left == 0);
        if (last) hdr_state = ST_HDR0;
        if (!cur_dropped) begin
          kb      = cur_key[8*(3-key_pos) +: 8];
          key_pos = key_pos + 1'b1;
          queue_result(KIND_BYTE, b ^ kb, last);
        end
      end
      default: hdr_state = ST_HDR0;
    endcase
  endfunction

  // Call at a rising edge. Leaves tvalid high unless a gap follows.
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    deframe_byte(b);
    bytes_sent++;
    gap = tx_idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drain();
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    // header words leave nothing in the queue; let the pipeline settle
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(input logic [31:0] value);
    wait_drain();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid    <= 1'b0;
    length_limit = value;
  endtask

  task automatic send_header(input logic fin, input logic [3:0] op, input logic masked,
                             input logic [31:0] key, input logic [63:0] len,
                             input len_enc_t enc);
    logic [6:0] code;
    logic [2:0] rsv;
    int         ext_bytes;
    case (enc)
      ENC_16: begin
        code      = LEN_CODE_16;
        ext_bytes = 2;
      end
      ENC_64: begin
        code      = LEN_CODE_64;
        ext_bytes = 8;
      end
      default: begin
        code      = len[6:0];
        ext_bytes = 0;
      end
    endcase
    rsv = 3'($urandom_range(0, 7));
    send_byte({fin, rsv, op});
    send_byte({masked, code});
    for (int i = ext_bytes - 1; i >= 0; i--) send_byte(len[8*i +: 8]);
    if (masked) begin
      for (int i = 3; i >= 0; i--) send_byte(key[8*i +: 8]);
    end
  endtask

  task automatic send_body(input int unsigned n);
    logic [7:0] b;
    repeat (n) begin
      b = 8'($urandom_range(0, 255));
      send_byte(b);
    end
  endtask

  task automatic send_frame(input logic fin, input logic [3:0] op, input logic masked,
                            input logic [31:0] key, input int unsigned len,
                            input len_enc_t enc);
    send_header(fin, op, masked, key, {32'd0, len}, enc);
    send_body(len);
  endtask

  task automatic send_random_frame();
    int unsigned r;
    int unsigned len;
    len_enc_t    enc;
    logic        masked;
    logic        fin;
    logic [3:0]  op;
    r = $urandom_range(0, 99);
    if (r < 12) len = 0;
    else if (r < 94) len = $urandom_range(1, 24);
    else len = $urandom_range(126, 150);
    r = $urandom_range(0, 9);
    if (len > 125) begin
      if (r < 8) enc = ENC_16;
      else enc = ENC_64;
    end else if (r < 7) begin
      enc = ENC_SHORT;
    end else if (r < 9) begin
      enc = ENC_16;
    end else begin
      enc = ENC_64;
    end
    masked = ($urandom_range(0, 3) != 0);
    fin    = 1'($urandom_range(0, 1));
    op     = 4'($urandom_range(0, 15));
    send_frame(fin, op, masked, $urandom, len, enc);
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_reset_limit();
    send_frame(1'b0, 4'h0, 1'b0, 32'h0, 0, ENC_SHORT);
    send_frame(1'b1, 4'hF, 1'b1, 32'hFFFF_FFFF, 3, ENC_SHORT);
    send_frame(1'b1, 4'h1, 1'b0, 32'h0, 2, ENC_SHORT);
  endtask

  task automatic test_header_forms();
    write_limit(32'd8);
    send_frame(1'b1, 4'h2, 1'b1, $urandom, 0, ENC_SHORT);  // empty after key
    send_frame(1'b0, 4'h9, 1'b1, $urandom, 8, ENC_SHORT);  // exactly at limit
    send_frame(1'b1, 4'hA, 1'b1, $urandom, 9, ENC_SHORT);  // one over, masked
    send_frame(1'b0, 4'h8, 1'b0, 32'h0, 9, ENC_SHORT);     // one over, plain
    send_frame(1'b1, 4'h0, 1'b0, 32'h0, 2, ENC_16);        // non-minimal 16-bit
    send_frame(1'b1, 4'h1, 1'b1, $urandom, 0, ENC_64);     // non-minimal 64-bit
    send_frame(1'b0, 4'h2, 1'b1, $urandom, 3, ENC_64);
  endtask

  task automatic test_limit_extremes();
    write_limit(32'd0);
    send_frame(1'b1, 4'h1, 1'b0, 32'h0, 0, ENC_SHORT);
    send_frame(1'b1, 4'h1, 1'b1, $urandom, 0, ENC_16);
    send_frame(1'b0, 4'h2, 1'b0, 32'h0, 1, ENC_SHORT);
    send_frame(1'b1, 4'h2, 1'b1, $urandom, 2, ENC_16);
    write_limit(32'hFFFF_FFFF);
    send_frame(1'b1, 4'hF, 1'b1, $urandom, 5, ENC_64);
    send_frame(1'b0, 4'h0, 1'b0, 32'h0, 128, ENC_16);
    write_limit($urandom);
    repeat (1) send_random_frame();
  endtask

  task automatic test_back_to_back();
    write_limit(32'd20);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    repeat (5) send_random_frame();
    wait_drain();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  task automatic test_output_stall();
    tx_idle_on = 1'b0;
    rx_hold    = 300;
    repeat (4) send_frame(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)), 1'b1,
                          $urandom, $urandom_range(6, 12), ENC_SHORT);
    // pause until everything is out
    wait_drain();
    tx_idle_on = 1'b1;
  endtask

  task automatic test_random_stream();
    int unsigned stop_at;
    logic [31:0] limits[3];
    limits[0] = 32'd12;
    limits[1] = MAX_LEN_RESET;
    limits[2] = $urandom_range(0, 30);
    for (int p = 0; p < 3; p++) begin
      write_limit(limits[p]);
      stop_at = bytes_sent + RANDOM_BYTES / 3;
      while (bytes_sent < stop_at) send_random_frame();
    end
  endtask

  // A length with its top bit set is always over the limit; its payload never
  // ends, so this runs last and the trailing noise must produce nothing.
  task automatic test_huge_length();
    logic [63:0] len;
    write_limit(32'hFFFF_FFFF);
    len = {1'b1, 31'($urandom), 32'($urandom)};
    send_header(1'b1, 4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)), $urandom, len,
                ENC_64);
    send_body(30);
  endtask

  // ---------------------------------------------------------------- pacing

  initial begin : rx_pacing
    int unsigned stall;
    stall = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold > 0) begin
        out_tready <= 1'b0;
        rx_hold--;
      end else if (stall > 0) begin
        out_tready <= 1'b0;
        stall--;
      end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
        stall = pick_gap();
        out_tready <= (stall == 0);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- checking

  always @(posedge clk) begin : result_check
    frame_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        mismatch_count++;
        $display("%0t unexpected result k=%0d d=%h l=%b f=%b op=%h", $time,
                 out_tuser, out_tdata[7:0], out_tlast, out_tdata[8], out_tdata[12:9]);
      end else begin
        want = expected_results.pop_front();
        if (want.kind !== out_tuser || want.data !== out_tdata[7:0] ||
            want.last !== out_tlast || want.fin !== out_tdata[8] ||
            want.opcode !== out_tdata[12:9]) begin
          mismatch_count++;
          $display("%0t mismatch exp k=%0d d=%h l=%b f=%b op=%h got k=%0d d=%h l=%b f=%b op=%h",
                   $time, want.kind, want.data, want.last, want.fin, want.opcode,
                   out_tuser, out_tdata[7:0], out_tlast, out_tdata[8], out_tdata[12:9]);
        end
      end
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  // ---------------------------------------------------------------- main

  initial begin
    rst_n      <= 1'b0;
    cfg_valid  <= 1'b0;
    cfg_data   <= '0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    rx_hold    = 0;
    mismatch_count = 0;
    bytes_sent = 0;
    parser_reset();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_limit();
    test_header_forms();
    test_limit_extremes();
    test_back_to_back();
    test_output_stall();
    test_random_stream();
    test_huge_length();

    wait_drain();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
